// ===== rtl/core/dhrgb_pkg.sv =====
package dhrgb_pkg;

  localparam int HsvW  = 10;
  localparam int RgbW  = 12;
  localparam int PctW  = 7;
  localparam int WgtW  = 8;
  localparam int ProdW = 2 * HsvW;

  localparam logic [HsvW-1:0] HSV_FULL    = HsvW'(1000);
  localparam logic [HsvW-1:0] SECTOR_SPAN = HsvW'(166);
  localparam logic [HsvW-1:0] DOUBLE_SPAN = HsvW'(333);
  localparam logic [PctW-1:0] BLUE_RESET  = PctW'(30);
  localparam logic [PctW-1:0] PCT_FULL    = PctW'(100);

  // exact reciprocals: floor(n/d) == (n*K) >> S over the ranges used here
  localparam int               SH_1000    = 30;
  localparam logic [20:0]      RECIP_1000 = 21'd1073742;
  localparam int               SH_166     = 28;
  localparam logic [20:0]      RECIP_166  = 21'd1617082;
  localparam int               SH_100     = 26;
  localparam logic [19:0]      RECIP_100  = 20'd671089;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [0:0] REG_BLUE_PCT = 1'b0;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HsvW-1:0] hue;
    logic [HsvW-1:0] saturation;
    logic [HsvW-1:0] brightness;
    logic [HsvW-1:0] led_level;
  } in_item_t;

  typedef struct packed {
    logic [RgbW-1:0] red;
    logic [RgbW-1:0] green;
    logic [RgbW-1:0] blue;
  } out_item_t;

  typedef struct packed {
    sector_t          sector;
    logic [WgtW-1:0]  weight;
    logic [HsvW-1:0]  sat;
    logic [ProdW-1:0] vl;
  } que_item_t;

  function automatic logic [HsvW-1:0] clamp_full(input logic [HsvW-1:0] x);
    clamp_full = (x > HSV_FULL) ? HSV_FULL : x;
  endfunction

endpackage

// ===== rtl/core/dimmed_hsv_to_rgb_led_color.sv =====
// Throughput: one transaction per cycle; a four-entry queue parts the classifying front
// from the ten-stage multiply pipeline, which stalls as a whole on out_ready.
// No pipeline stage holds a multiplier wider than 22 by 21 bits.
// Reset: rst_n is synchronous, active low; it empties front, queue and pipeline
// and sets blue_percent to 30.
module dimmed_hsv_to_rgb_led_color #(
  parameter int FIFO_DEPTH = dhrgb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dhrgb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dhrgb_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic                       wr_valid, wr_ready, rd_valid, rd_ready;
  dhrgb_pkg::que_item_t       wr_data, rd_data;
  logic [dhrgb_pkg::PctW-1:0] blue_pct;

  dhrgb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .blue_pct (blue_pct)
  );

  dhrgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  dhrgb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  dhrgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_ready  (rd_ready),
    .rd_data   (rd_data),
    .blue_pct  (blue_pct),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/dhrgb_cfg.sv =====
module dhrgb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [dhrgb_pkg::PctW-1:0] blue_pct
);

  logic [dhrgb_pkg::PctW-1:0] pct_r;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == dhrgb_pkg::REG_BLUE_PCT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= dhrgb_pkg::BLUE_RESET;
    end else if (wr_en) begin
      pct_r <= pwdata[dhrgb_pkg::PctW-1:0];
    end
  end

  assign prdata = (paddr[2] == dhrgb_pkg::REG_BLUE_PCT) ?
                  {{(32-dhrgb_pkg::PctW){1'b0}}, pct_r} : 32'd0;

  // treat anything above a hundred percent as full
  assign blue_pct = (pct_r > dhrgb_pkg::PCT_FULL) ? dhrgb_pkg::PCT_FULL : pct_r;

endmodule

// ===== rtl/core/dhrgb_front.sv =====
module dhrgb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dhrgb_pkg::in_item_t  in_data,
  output logic                 wr_valid,
  input  logic                 wr_ready,
  output dhrgb_pkg::que_item_t wr_data
);

  localparam int W = dhrgb_pkg::HsvW;

  logic                 f_valid_r;
  dhrgb_pkg::que_item_t f_item_r;
  dhrgb_pkg::que_item_t item_nxt;
  logic [W-1:0]         hc, sc, vc, lc, tri_h;
  dhrgb_pkg::sector_t   sec;

  always_comb begin
    hc = dhrgb_pkg::clamp_full(in_data.hue);
    sc = dhrgb_pkg::clamp_full(in_data.saturation);
    vc = dhrgb_pkg::clamp_full(in_data.brightness);
    lc = dhrgb_pkg::clamp_full(in_data.led_level);

    priority if (hc >= W'(5 * dhrgb_pkg::SECTOR_SPAN)) sec = dhrgb_pkg::SEC_M_R;
    else if (hc >= W'(4 * dhrgb_pkg::SECTOR_SPAN))     sec = dhrgb_pkg::SEC_B_M;
    else if (hc >= W'(3 * dhrgb_pkg::SECTOR_SPAN))     sec = dhrgb_pkg::SEC_C_B;
    else if (hc >= W'(2 * dhrgb_pkg::SECTOR_SPAN))     sec = dhrgb_pkg::SEC_G_C;
    else if (hc >= dhrgb_pkg::SECTOR_SPAN)             sec = dhrgb_pkg::SEC_Y_G;
    else                                               sec = dhrgb_pkg::SEC_R_Y;

    // fold hue into one double span
    priority if (hc >= W'(3 * dhrgb_pkg::DOUBLE_SPAN)) tri_h = hc - W'(3 * dhrgb_pkg::DOUBLE_SPAN);
    else if (hc >= W'(2 * dhrgb_pkg::DOUBLE_SPAN))     tri_h = hc - W'(2 * dhrgb_pkg::DOUBLE_SPAN);
    else if (hc >= dhrgb_pkg::DOUBLE_SPAN)             tri_h = hc - dhrgb_pkg::DOUBLE_SPAN;
    else                                               tri_h = hc;

    item_nxt.sector = sec;
    // weight is span minus distance from the span midpoint
    item_nxt.weight = (tri_h < dhrgb_pkg::SECTOR_SPAN) ?
                      dhrgb_pkg::WgtW'(tri_h) :
                      dhrgb_pkg::WgtW'(W'(2 * dhrgb_pkg::SECTOR_SPAN) - tri_h);
    item_nxt.sat    = sc;
    item_nxt.vl     = dhrgb_pkg::ProdW'(vc) * dhrgb_pkg::ProdW'(lc);
  end

  assign in_ready = !f_valid_r || wr_ready;
  assign wr_valid = f_valid_r;
  assign wr_data  = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item_r <= item_nxt;
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r |-> f_item_r.weight <= dhrgb_pkg::WgtW'(dhrgb_pkg::SECTOR_SPAN))
    else $error("weight above sector span");

endmodule

// ===== rtl/core/dhrgb_fifo.sv =====
module dhrgb_fifo #(
  parameter int DEPTH = dhrgb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  dhrgb_pkg::que_item_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output dhrgb_pkg::que_item_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dhrgb_pkg::que_item_t mem_r [DEPTH];
  logic [PW-1:0]        wp_r, rp_r;
  logic [CW-1:0]        count_r;
  logic                 push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/dhrgb_back.sv =====
module dhrgb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_valid,
  output logic                       rd_ready,
  input  dhrgb_pkg::que_item_t       rd_data,
  input  logic [dhrgb_pkg::PctW-1:0] blue_pct,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dhrgb_pkg::out_item_t       out_data
);

  localparam int W  = dhrgb_pkg::HsvW;
  localparam int R  = dhrgb_pkg::RgbW;
  localparam int SW = 22;  // channel times full scale

  logic       adv;
  logic [9:1] vld_r;
  logic       out_valid_r;

  // stage payloads
  logic [40:0]               q1_r;
  dhrgb_pkg::sector_t        sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;
  logic [dhrgb_pkg::WgtW-1:0] w1_r, w2_r, w3_r;
  logic [W-1:0]              s1_r;
  logic [W-1:0]              v2_r, v3_r, v4_r, v5_r;
  logic [19:0]               cs2_r;
  logic [40:0]               q3_r;
  logic [17:0]               cw4_r;
  logic [W-1:0]              c4_r, c5_r;
  logic [38:0]               q5_r;
  logic [SW-1:0]             r6_r, g6_r, b6_r;
  logic [42:0]               qr7_r, qg7_r, qb7_r;
  logic [R-1:0]              r8_r, g8_r, r9_r, g9_r;
  logic [18:0]               bp8_r;
  logic [38:0]               q9_r;
  dhrgb_pkg::out_item_t      out_r;

  logic [W-1:0] v2_nxt, c4_nxt, x6, m6, r6, g6, b6;

  assign adv       = !out_valid_r || out_ready;
  assign rd_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign v2_nxt = q1_r[dhrgb_pkg::SH_1000 +: W];
  assign c4_nxt = q3_r[dhrgb_pkg::SH_1000 +: W];

  always_comb begin
    x6 = q5_r[dhrgb_pkg::SH_166 +: W];
    m6 = v5_r - c5_r;
    unique case (sec5_r)
      dhrgb_pkg::SEC_R_Y: begin r6 = v5_r;    g6 = x6 + m6; b6 = m6;      end
      dhrgb_pkg::SEC_Y_G: begin r6 = x6 + m6; g6 = v5_r;    b6 = m6;      end
      dhrgb_pkg::SEC_G_C: begin r6 = m6;      g6 = v5_r;    b6 = x6 + m6; end
      dhrgb_pkg::SEC_C_B: begin r6 = m6;      g6 = x6 + m6; b6 = v5_r;    end
      dhrgb_pkg::SEC_B_M: begin r6 = x6 + m6; g6 = m6;      b6 = v5_r;    end
      default:            begin r6 = v5_r;    g6 = m6;      b6 = x6 + m6; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[8:1], rd_valid};
      out_valid_r <= vld_r[9];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // dimmed value = v * level / 1000
      q1_r   <= 41'(rd_data.vl) * 41'(dhrgb_pkg::RECIP_1000);
      sec1_r <= rd_data.sector;
      w1_r   <= rd_data.weight;
      s1_r   <= rd_data.sat;

      // chroma = v * s / 1000
      v2_r   <= v2_nxt;
      cs2_r  <= 20'(v2_nxt) * 20'(s1_r);
      sec2_r <= sec1_r;
      w2_r   <= w1_r;

      q3_r   <= 41'(cs2_r) * 41'(dhrgb_pkg::RECIP_1000);
      v3_r   <= v2_r;
      sec3_r <= sec2_r;
      w3_r   <= w2_r;

      // X = chroma * weight / 166
      cw4_r  <= 18'(c4_nxt) * 18'(w3_r);
      c4_r   <= c4_nxt;
      v4_r   <= v3_r;
      sec4_r <= sec3_r;

      q5_r   <= 39'(cw4_r) * 39'(dhrgb_pkg::RECIP_166);
      c5_r   <= c4_r;
      v5_r   <= v4_r;
      sec5_r <= sec4_r;

      // times 4095 as shift and subtract
      r6_r <= {r6, 12'd0} - SW'(r6);
      g6_r <= {g6, 12'd0} - SW'(g6);
      b6_r <= {b6, 12'd0} - SW'(b6);

      qr7_r <= 43'(r6_r) * 43'(dhrgb_pkg::RECIP_1000);
      qg7_r <= 43'(g6_r) * 43'(dhrgb_pkg::RECIP_1000);
      qb7_r <= 43'(b6_r) * 43'(dhrgb_pkg::RECIP_1000);

      r8_r  <= qr7_r[dhrgb_pkg::SH_1000 +: R];
      g8_r  <= qg7_r[dhrgb_pkg::SH_1000 +: R];
      bp8_r <= 19'(qb7_r[dhrgb_pkg::SH_1000 +: R]) * 19'(blue_pct);

      q9_r <= 39'(bp8_r) * 39'(dhrgb_pkg::RECIP_100);
      r9_r <= r8_r;
      g9_r <= g8_r;

      out_r.red   <= r9_r;
      out_r.green <= g9_r;
      out_r.blue  <= q9_r[dhrgb_pkg::SH_100 +: R];
    end
  end

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (r6 <= dhrgb_pkg::HSV_FULL) && (g6 <= dhrgb_pkg::HSV_FULL) &&
                 (b6 <= dhrgb_pkg::HSV_FULL))
    else $error("channel above full scale before 12-bit scaling");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dhrgb_pkg::*;

  localparam int unsigned RGB_FULL    = 4095;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          SETTLE      = 20;
  localparam logic [2:0]  BLUE_ADDR   = 3'(4 * REG_BLUE_PCT);

  class colour_scoreboard;
    out_item_t       expected_q[$];
    logic [PctW-1:0] blue_pct;
    int              errors;

    function new();
      blue_pct = BLUE_RESET;
      errors = 0;
    endfunction

    function automatic out_item_t predict_rgb(in_item_t it);
      int unsigned h, s, v, lvl, sec, c, x, m, tri_pos, span_dist, r, g, b, pct;
      out_item_t res;
      h   = (it.hue > HSV_FULL) ? HSV_FULL : it.hue;
      s   = (it.saturation > HSV_FULL) ? HSV_FULL : it.saturation;
      v   = (it.brightness > HSV_FULL) ? HSV_FULL : it.brightness;
      lvl = (it.led_level > HSV_FULL) ? HSV_FULL : it.led_level;
      v = v * lvl / HSV_FULL;
      sec = h / SECTOR_SPAN;
      c = v * s / HSV_FULL;
      tri_pos = h % DOUBLE_SPAN;
      span_dist = (tri_pos >= SECTOR_SPAN) ? (tri_pos - SECTOR_SPAN) :
                                             (SECTOR_SPAN - tri_pos);
      x = c * (SECTOR_SPAN - span_dist) / SECTOR_SPAN;
      m = v - c;
      // hue 996..1000 lands in a seventh sector and takes the magenta-red rule
      case (sec)
        SEC_R_Y: begin r = v;     g = x + m; b = m;     end
        SEC_Y_G: begin r = x + m; g = v;     b = m;     end
        SEC_G_C: begin r = m;     g = v;     b = x + m; end
        SEC_C_B: begin r = m;     g = x + m; b = v;     end
        SEC_B_M: begin r = x + m; g = m;     b = v;     end
        default: begin r = v;     g = m;     b = x + m; end
      endcase
      r = r * RGB_FULL / HSV_FULL;
      g = g * RGB_FULL / HSV_FULL;
      b = b * RGB_FULL / HSV_FULL;
      pct = (blue_pct > PCT_FULL) ? PCT_FULL : blue_pct;
      b = b * pct / PCT_FULL;
      res.red   = r[RgbW-1:0];
      res.green = g[RgbW-1:0];
      res.blue  = b[RgbW-1:0];
      return res;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(predict_rgb(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_rgb;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        errors++;
        return;
      end
      exp_rgb = expected_q.pop_front();
      if (got.red !== exp_rgb.red) begin
        $display("%0t: red mismatch, expected %0d, got %0d", $time, exp_rgb.red, got.red);
        errors++;
      end
      if (got.green !== exp_rgb.green) begin
        $display("%0t: green mismatch, expected %0d, got %0d", $time,
                 exp_rgb.green, got.green);
        errors++;
      end
      if (got.blue !== exp_rgb.blue) begin
        $display("%0t: blue mismatch, expected %0d, got %0d", $time,
                 exp_rgb.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit stall_en = 1'b1;
  bit gap_en = 1'b1;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  colour_scoreboard sb = new();

  dimmed_hsv_to_rgb_led_color uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    int n;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (59) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(int h, int s, int v, int lvl);
    in_item_t it;
    it.hue        = h[HsvW-1:0];
    it.saturation = s[HsvW-1:0];
    it.brightness = v[HsvW-1:0];
    it.led_level  = lvl[HsvW-1:0];
    return it;
  endfunction

  // mostly in range, now and then anything the field can carry
  function automatic int rand_field();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, 1000);
  endfunction

  task automatic send_item(in_item_t it);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk) in_valid <= 1'b0;
    end
  endtask

  task automatic send_random(int count);
    repeat (count) send_item(make_item(rand_field(), rand_field(), rand_field(),
                                       rand_field()));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_blue_pct(int value);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BLUE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.blue_pct = value[PctW-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int hues[20] = '{0, 1, 165, 166, 331, 332, 333, 498, 499, 664,
                     665, 666, 829, 830, 831, 995, 996, 999, 1000, 1023};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // sector boundaries and clamping at the reset blue percentage
    foreach (hues[i]) send_item(make_item(hues[i], 1000, 1000, 1000));
    send_item(make_item(500, 0, 1000, 1000));
    send_item(make_item(500, 1000, 0, 1000));
    send_item(make_item(500, 1000, 1000, 0));
    send_item(make_item(1023, 1023, 1023, 1023));
    send_item(make_item(700, 1023, 500, 1023));
    send_random(250);

    write_blue_pct(100);
    send_random(40);
    hold_off_req = 1'b1;
    send_random(210);

    write_blue_pct(0);
    send_random(200);

    write_blue_pct(127);
    send_random(200);

    write_blue_pct($urandom_range(1, 99));
    send_random(100);
    wait_drained();
    send_random(100);

    write_blue_pct($urandom_range(0, 127));
    stall_en = 1'b0;
    gap_en = 1'b0;
    send_random(250);

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
